@@ design/ts_pes_pts_restamp_macros.svh @@
// Assertion macros shared by the checker.
`ifndef TS_PES_PTS_RESTAMP_MACROS_SVH
`define TS_PES_PTS_RESTAMP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define TSPTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("tspts assertion failed");

// Next-cycle implication, disabled while reset is low.
`define TSPTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("tspts assertion failed");

`endif

@@ design/tspts_pkg.sv @@
package tspts_pkg;

    localparam int PACKET_BYTES_DEF = 188;
    localparam int PID_W            = 13;
    localparam int MS_W             = 24;
    localparam int TICK_W           = 33;   // PTS width
    localparam int PO_W             = 9;    // payload offset, up to 5 + 255
    localparam int HDR_BYTES        = 4;
    localparam int MAX_RESULTS      = 5;
    localparam int QUEUE_DEPTH      = 16;

    typedef enum logic {
        REG_TARGET_PID = 1'b0,
        REG_SHIFT_MS   = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [PID_W-1:0]  target_pid;
        logic [TICK_W-1:0] shift_ticks;   // shift_ms * 90, mod 2^33
    } cfg_t;

    typedef struct packed {
        logic [2:0]                   n;     // beats to push, 0..5
        logic [MAX_RESULTS-1:0][7:0]  data;  // data[0] goes out first
    } push_t;

endpackage

@@ design/tspts_regs.sv @@
module tspts_regs (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output tspts_pkg::cfg_t    cfg
);
    import tspts_pkg::*;

    logic [PID_W-1:0]  pid_reg;
    logic [MS_W-1:0]   ms_reg;
    logic [TICK_W-1:0] ticks_reg;
    logic [TICK_W-1:0] wr_ms_x;
    logic [TICK_W-1:0] wr_ticks;
    reg_idx_t          idx;
    logic              wr_en;

    assign idx   = reg_idx_t'(paddr[2]);
    assign wr_en = psel && penable && pwrite;
    assign pready = 1'b1;

    // x*90 = x*64 + x*16 + x*8 + x*2
    assign wr_ms_x  = {{(TICK_W-MS_W){pwdata[MS_W-1]}}, pwdata[MS_W-1:0]};
    assign wr_ticks = (wr_ms_x << 6) + (wr_ms_x << 4) + (wr_ms_x << 3) + (wr_ms_x << 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pid_reg   <= '0;
            ms_reg    <= '0;
            ticks_reg <= '0;
        end else if (wr_en) begin
            case (idx)
                REG_TARGET_PID: pid_reg <= pwdata[PID_W-1:0];
                REG_SHIFT_MS: begin
                    ms_reg    <= pwdata[MS_W-1:0];
                    ticks_reg <= wr_ticks;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_TARGET_PID: prdata = {{(32-PID_W){1'b0}}, pid_reg};
            REG_SHIFT_MS:   prdata = {{(32-MS_W){1'b0}}, ms_reg};
            default:        prdata = '0;
        endcase
    end

    assign cfg.target_pid  = pid_reg;
    assign cfg.shift_ticks = ticks_reg;

endmodule

@@ design/tspts_parser.sv @@
module tspts_parser #(
    parameter int PACKET_BYTES = tspts_pkg::PACKET_BYTES_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_accept,
    input  logic [7:0]         in_byte,
    input  tspts_pkg::cfg_t    cfg,
    output tspts_pkg::push_t   push
);
    import tspts_pkg::*;

    localparam int POS_W = $clog2(PACKET_BYTES);
    localparam logic [POS_W-1:0] POS_LAST   = POS_W'(PACKET_BYTES - 1);
    localparam logic [POS_W-1:0] HDR_SYNC   = POS_W'(0);
    localparam logic [POS_W-1:0] HDR_PID_HI = POS_W'(1);
    localparam logic [POS_W-1:0] HDR_PID_LO = POS_W'(2);
    localparam logic [POS_W-1:0] HDR_FLAGS  = POS_W'(3);
    localparam logic [POS_W-1:0] HDR_AF_LEN = POS_W'(4);
    localparam logic [PO_W-1:0]  PO_HDR     = PO_W'(HDR_BYTES);
    localparam logic [PO_W-1:0]  PO_NONE    = PO_W'(PACKET_BYTES);
    localparam logic [PO_W-1:0]  PO_AF_BASE = PO_W'(HDR_BYTES + 1);
    localparam logic [PO_W:0]    PKT_END_X  = (PO_W+1)'(PACKET_BYTES);

    logic [POS_W-1:0] pos_reg, pos_next;
    logic [4:0]       pid_hi_reg, pid_hi_next;
    logic             unit_start_reg, unit_start_next;
    logic             pid_match_reg, pid_match_next;
    logic             has_af_reg, has_af_next;
    logic [PO_W-1:0]  po_reg, po_next;
    logic             pts_reg, pts_next;
    logic [3:0][7:0]  hold_reg;

    logic [PO_W:0]    pos_x, flag_at, first_at, end_at;
    logic [2:0]       k;
    logic             in_pts, hold_wr;
    logic [TICK_W-1:0] pts_old, pts_new;

    assign pos_x    = (PO_W+1)'(pos_reg);
    assign flag_at  = {1'b0, po_reg} + (PO_W+1)'(7);
    assign first_at = {1'b0, po_reg} + (PO_W+1)'(9);
    assign end_at   = {1'b0, po_reg} + (PO_W+1)'(13);
    assign k        = 3'(pos_x - first_at);
    assign in_pts   = pts_reg && (pos_x >= first_at) && (pos_x <= end_at);

    // fifth PTS byte arrives on in_byte, the first four sit in hold_reg
    assign pts_old = {hold_reg[0][3:1], hold_reg[1], hold_reg[2][7:1], hold_reg[3], in_byte[7:1]};
    assign pts_new = pts_old + cfg.shift_ticks;

    always_comb begin
        pos_next        = (pos_reg == POS_LAST) ? '0 : pos_reg + POS_W'(1);
        pid_hi_next     = pid_hi_reg;
        unit_start_next = unit_start_reg;
        pid_match_next  = pid_match_reg;
        has_af_next     = has_af_reg;
        po_next         = po_reg;
        pts_next        = pts_reg;
        hold_wr         = 1'b0;
        push.n          = 3'd1;
        push.data       = '0;
        push.data[0]    = in_byte;

        if (pos_reg == HDR_SYNC) begin
            pts_next = 1'b0;
            po_next  = PO_HDR;
        end else if (pos_reg == HDR_PID_HI) begin
            pid_hi_next     = in_byte[4:0];
            unit_start_next = in_byte[6];
        end else if (pos_reg == HDR_PID_LO) begin
            pid_match_next = ({pid_hi_reg, in_byte} == cfg.target_pid);
        end else if (pos_reg == HDR_FLAGS) begin
            has_af_next = in_byte[5];
            po_next     = in_byte[4] ? PO_HDR : PO_NONE;
        end else if (pos_reg == HDR_AF_LEN) begin
            if (has_af_reg && po_reg == PO_HDR) begin
                po_next = PO_AF_BASE + {1'b0, in_byte};
            end
        end else if (pos_x == flag_at) begin
            // PTS flag byte; whole PTS must fit before the packet end
            if (pid_match_reg && unit_start_reg && in_byte[7] && end_at < PKT_END_X) begin
                pts_next = 1'b1;
            end
        end else if (in_pts) begin
            if (k < 3'd4) begin
                hold_wr = 1'b1;
                push.n  = 3'd0;
            end else begin
                push.n       = 3'd5;
                push.data[0] = {hold_reg[0][7:4], pts_new[32:30], 1'b1};
                push.data[1] = pts_new[29:22];
                push.data[2] = {pts_new[21:15], 1'b1};
                push.data[3] = pts_new[14:7];
                push.data[4] = {pts_new[6:0], 1'b1};
                pts_next     = 1'b0;
            end
        end

        if (!in_accept) begin
            push.n = 3'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg        <= '0;
            pid_hi_reg     <= '0;
            unit_start_reg <= 1'b0;
            pid_match_reg  <= 1'b0;
            has_af_reg     <= 1'b0;
            po_reg         <= PO_HDR;
            pts_reg        <= 1'b0;
        end else if (in_accept) begin
            pos_reg        <= pos_next;
            pid_hi_reg     <= pid_hi_next;
            unit_start_reg <= unit_start_next;
            pid_match_reg  <= pid_match_next;
            has_af_reg     <= has_af_next;
            po_reg         <= po_next;
            pts_reg        <= pts_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept && hold_wr) begin
            hold_reg[k[1:0]] <= in_byte;
        end
    end

endmodule

@@ design/tspts_queue.sv @@
module tspts_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  tspts_pkg::push_t   push,
    output logic               space_ok,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [7:0]         m_tdata,
    output logic               m_tlast
);
    import tspts_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam logic [PTR_W:0] SPACE_MAX = (PTR_W+1)'(QUEUE_DEPTH - MAX_RESULTS);

    logic [7:0]       data_reg [QUEUE_DEPTH];
    logic             last_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg, tail_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic [PTR_W-1:0] slot [QUEUE_DEPTH];
    logic             pop;
    logic [PTR_W:0]   push_x;

    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = data_reg[head_reg];
    assign m_tlast  = last_reg[head_reg];
    assign space_ok = (count_reg <= SPACE_MAX);
    assign push_x   = (PTR_W+1)'(push.n);
    assign count_next = count_reg + push_x - (PTR_W+1)'(pop);

    // distance of each entry from the tail
    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot[i] = PTR_W'(i) - tail_reg;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if ((PTR_W+1)'(slot[i]) < push_x) begin
                data_reg[i] <= push.data[slot[i][2:0]];
                last_reg[i] <= ((PTR_W+1)'(slot[i]) == push_x - (PTR_W+1)'(1));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            tail_reg  <= tail_reg + PTR_W'(push.n);
            head_reg  <= head_reg + PTR_W'(pop);
            count_reg <= count_next;
        end
    end

endmodule

@@ design/ts_pes_pts_restamp.sv @@
// Pass-through bytes: an accepted s_ beat goes into the registered output queue.
// PTS bytes: the first four are held; the fifth releases five beats, one per cycle
// while m_tready is high. Throughput: one byte per cycle (m_tready high), set by the
// 16-entry output queue; s_tready drops only while more than 11 beats wait in it.
// Reset (aresetn low, synchronous): parser state, queue pointers and registers cleared.
module ts_pes_pts_restamp #(
    parameter int PACKET_BYTES = tspts_pkg::PACKET_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] out_byte
    output logic        m_tlast,    // run_last: last beat released by one input beat
    // register port: 0x0 target_pid, 0x4 shift in ms (signed, 24 bit)
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tspts_pkg::*;

    cfg_t  cfg;
    push_t push;
    logic  s_accept;

    assign s_accept = s_tvalid && s_tready;

    // Register file; the offset is converted to 90 kHz ticks on write so the
    // release path only sees one 33-bit add.
    tspts_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Header parse, PTS hold and restamp; emits 0, 1 or 5 beats per input beat.
    tspts_parser #(
        .PACKET_BYTES (PACKET_BYTES)
    ) u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_accept),
        .in_byte   (s_tdata),
        .cfg       (cfg),
        .push      (push)
    );

    // Output queue absorbs the five-beat burst while input keeps flowing.
    tspts_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .space_ok (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

@@ design/tspts_checker.sv @@
`include "ts_pes_pts_restamp_macros.svh"

module tspts_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       pready
);

    // stalled result beat holds
    `TSPTS_ASSERT_NXT(a_m_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // input back-pressure only while a backlog is waiting
    `TSPTS_ASSERT_IMP(a_bp_backlog, aclk, aresetn, !s_tready, m_tvalid)

    // queue comes out of reset empty
    `TSPTS_ASSERT_IMP(a_reset_empty, aclk, aresetn, $rose(aresetn), !m_tvalid && s_tready)

    // register port never waits
    `TSPTS_ASSERT_IMP(a_pready, aclk, aresetn, 1'b1, pready)

endmodule

bind ts_pes_pts_restamp tspts_checker u_tspts_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

@@ verif/tb_ts_pes_pts_restamp.sv @@
module tb_ts_pes_pts_restamp;
    import tspts_pkg::*;

    localparam int PKT         = PACKET_BYTES_DEF;
    localparam int SEND_BYTES  = 130;   // stream bytes sent in the run
    localparam int QUIET_LIMIT = 2000;  // cycles with no beat and no register access
    localparam int PRINT_CAP   = 50;

    typedef logic [4:0][7:0] pts_bytes_t;  // [0] is the first PTS byte on the wire

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } ts_beat_t;

    // clock, reset
    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // DUT ports, all driven known from time zero
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    ts_pes_pts_restamp #(
        .PACKET_BYTES(PKT)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // stimulus store and expected output stream
    logic [7:0] ts_bytes_to_send [$];
    ts_beat_t   out_stream_due [$];
    logic [7:0] pkt_buf [PKT];
    int         mismatches = 0;
    bit         gaps_on    = 1'b0;

    // predictor state: shadow registers and parser
    logic [12:0]        cfg_target_pid;
    logic signed [23:0] cfg_shift_ms;
    int                 ts_pos;
    logic [4:0]         pid_hi;
    bit                 pusi_seen;
    bit                 pid_hit;
    bit                 adapt_seen;
    int                 pay_off;
    bit                 pts_armed;
    pts_bytes_t         pts_hold;

    function automatic logic [2:0] reg_addr(input reg_idx_t r);
        return 3'({r, 2'b00});
    endfunction

    // PTS + ms*90 mod 2^33; keeps the top nibble of byte 0, forces markers
    function automatic pts_bytes_t shift_pts(input pts_bytes_t in_b,
                                             input logic signed [23:0] ms);
        logic [32:0] ts;
        logic [32:0] moved;
        pts_bytes_t  res;
        ts = {in_b[0][3:1], in_b[1], in_b[2][7:1], in_b[3], in_b[4][7:1]};
        moved = 33'(longint'(ts) + longint'(ms) * 90);
        res[0] = {in_b[0][7:4], moved[32:30], 1'b1};
        res[1] = moved[29:22];
        res[2] = {moved[21:15], 1'b1};
        res[3] = moved[14:7];
        res[4] = {moved[6:0], 1'b1};
        return res;
    endfunction

    // one accepted stream byte: advance the parser, queue what comes out
    task automatic track_ts_byte(input logic [7:0] b);
        int         p;
        int         po;
        int         k;
        int         n_out;
        pts_bytes_t rs;
        p = ts_pos;
        po = pay_off;
        n_out = 1;
        if (p == 0) begin
            pts_armed = 1'b0;
            pay_off = 4;
        end else if (p == 1) begin
            pid_hi = b[4:0];
            pusi_seen = b[6];
        end else if (p == 2) begin
            pid_hit = ({pid_hi, b} == cfg_target_pid);
        end else if (p == 3) begin
            adapt_seen = b[5];
            pay_off = b[4] ? 4 : PKT;
        end else if (p == 4) begin
            if (adapt_seen && pay_off == 4)
                pay_off = 5 + b;
        end else if (p == po + 7) begin
            if (pid_hit && pusi_seen && b[7] && po + 13 < PKT)
                pts_armed = 1'b1;
        end else if (pts_armed && p >= po + 9 && p <= po + 13) begin
            k = p - po - 9;
            pts_hold[k] = b;
            n_out = 0;
            if (k == 4) begin
                rs = shift_pts(pts_hold, cfg_shift_ms);
                for (int i = 0; i < 5; i++)
                    out_stream_due.push_back('{data: rs[i], last: (i == 4)});
                pts_armed = 1'b0;
            end
        end
        if (n_out == 1)
            out_stream_due.push_back('{data: b, last: 1'b1});
        ts_pos = (p + 1 >= PKT) ? 0 : p + 1;
    endtask

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatches < PRINT_CAP)
            $display("[%0t] mismatch %s: got %02h want %02h", $time, what, got, want);
        mismatches++;
    endtask

    // monitor: predict on s_ beats, compare m_ beats, mirror register writes
    always @(posedge aclk) begin
        ts_beat_t due;
        if (!aresetn) begin
            cfg_target_pid = '0;
            cfg_shift_ms = '0;
            ts_pos = 0;
            pid_hi = '0;
            pusi_seen = 1'b0;
            pid_hit = 1'b0;
            adapt_seen = 1'b0;
            pay_off = 4;
            pts_armed = 1'b0;
            out_stream_due.delete();
        end else begin
            if (s_tvalid && s_tready)
                track_ts_byte(s_tdata);
            if (m_tvalid && m_tready) begin
                if (out_stream_due.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata, 8'h00);
                end else begin
                    due = out_stream_due.pop_front();
                    if (m_tdata !== due.data)
                        report_mismatch("out_byte", m_tdata, due.data);
                    if (m_tlast !== due.last)
                        report_mismatch("run_last", 8'(m_tlast), 8'(due.last));
                end
            end
            // registers change after this edge: a beat taken now saw the old values
            if (psel && penable && pwrite && pready) begin
                if (paddr == reg_addr(REG_TARGET_PID))
                    cfg_target_pid = pwdata[12:0];
                else if (paddr == reg_addr(REG_SHIFT_MS))
                    cfg_shift_ms = pwdata[23:0];
            end
        end
    end

    // driver: bursts of random length, random gaps between them when enabled
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            burst_left = 0;
            gap_left = 0;
        end else if (!s_tvalid || s_tready) begin
            if (gap_left > 0) begin
                gap_left--;
                s_tvalid <= 1'b0;
            end else if (ts_bytes_to_send.size() == 0) begin
                s_tvalid <= 1'b0;
            end else begin
                s_tvalid <= 1'b1;
                s_tdata <= ts_bytes_to_send.pop_front();
                if (burst_left == 0)
                    burst_left = $urandom_range(1, 24);
                burst_left--;
                if (burst_left == 0 && gaps_on)
                    gap_left = $urandom_range(1, 8);
            end
        end
    end

    // receiver: rotating ready pattern, reloaded when its random run length runs out
    logic [15:0] rdy_pat  = '1;
    int          rdy_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rdy_left = 0;
        end else begin
            if (rdy_left == 0) begin
                rdy_left = $urandom_range(16, 96);
                case ($urandom_range(0, 3))
                    0: rdy_pat = '1;           // no stalls
                    1: rdy_pat = 16'hAAAA;     // alternating ready and stall
                    default: rdy_pat = 16'($urandom) | 16'h0101;
                endcase
            end
            m_tready <= rdy_pat[0];
            rdy_pat = {rdy_pat[0], rdy_pat[15:1]};
            rdy_left--;
        end
    end

    // watchdog: nothing moving for too long means a hang
    int quiet_cycles = 0;

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_ts_pes_pts_restamp NOT OK");
            $finish;
        end
    end

    // setup + access, write lands at the edge with penable and pready high
    task automatic write_reg(input reg_idx_t r, input logic [31:0] v);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= reg_addr(r);
        pwdata <= v;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic write_offset(input logic [23:0] ms);
        write_reg(REG_SHIFT_MS, {{8{ms[23]}}, ms});
    endtask

    // one 188-byte packet into pkt_buf; noise gives random bytes only
    task automatic build_packet(input logic [12:0] pid, input bit pusi, input bit af,
                                input bit pl, input logic [7:0] af_len,
                                input bit pts_flag, input logic [32:0] pts,
                                input bit noise);
        int         po;
        logic [7:0] pes [14];
        for (int i = 0; i < PKT; i++)
            pkt_buf[i] = 8'($urandom);
        if (noise)
            return;
        pkt_buf[0] = 8'h47;
        pkt_buf[1] = {pkt_buf[1][7], pusi, pkt_buf[1][5], pid[12:8]};
        pkt_buf[2] = pid[7:0];
        pkt_buf[3] = {pkt_buf[3][7:6], af, pl, pkt_buf[3][3:0]};
        if (af)
            pkt_buf[4] = af_len;
        po = !pl ? PKT : (af ? 5 + af_len : 4);
        // PES header with random marker bits and random top nibble
        pes[0] = 8'h00;
        pes[1] = 8'h00;
        pes[2] = 8'h01;
        pes[3] = 8'hE0;
        pes[4] = 8'($urandom);
        pes[5] = 8'($urandom);
        pes[6] = 8'h84;
        pes[7] = {pts_flag, 7'($urandom)};
        pes[8] = 8'($urandom);
        pes[9] = {4'($urandom), pts[32:30], 1'($urandom)};
        pes[10] = pts[29:22];
        pes[11] = {pts[21:15], 1'($urandom)};
        pes[12] = pts[14:7];
        pes[13] = {pts[6:0], 1'($urandom)};
        for (int j = 0; j < 14; j++)
            if (po + j < PKT)
                pkt_buf[po + j] = pes[j];
    endtask

    task automatic queue_bytes(input int first, input int last);
        for (int i = first; i <= last; i++)
            ts_bytes_to_send.push_back(pkt_buf[i]);
    endtask

    // wait until the sender is idle and all due beats are seen, then settle
    task automatic wait_drained();
        do @(negedge aclk);
        while (ts_bytes_to_send.size() != 0 || s_tvalid || out_stream_due.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    initial begin
        int po;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // top PID, largest positive shift, short adaptation field
        write_reg(REG_TARGET_PID, 32'd8191);
        write_offset(24'h7F_FFFF);
        gaps_on = 1'b1;
        build_packet(13'd8191, 1, 1, 1, 8'd3, 1, 33'h0_0000_0100, 0);
        po = 5 + 3;

        // stop with three PTS bytes held, retune both registers, then finish:
        // PID match was latched already, largest negative shift applies at
        // release and wraps the small PTS downward
        queue_bytes(0, po + 11);
        wait_drained();
        write_offset(24'h80_0000);
        write_reg(REG_TARGET_PID, 32'h0155);
        queue_bytes(po + 12, SEND_BYTES - 1);
        wait_drained();

        // quiet tail: catch any beat the DUT emits beyond the prediction
        do @(negedge aclk);
        while (ts_bytes_to_send.size() != 0 || s_tvalid || out_stream_due.size() != 0);
        repeat (20) @(posedge aclk);
        if (mismatches == 0 && out_stream_due.size() == 0)
            $display("tb_ts_pes_pts_restamp OK");
        else
            $display("tb_ts_pes_pts_restamp NOT OK");
        $finish;
    end

endmodule
